// File: hdl/tss_pkg.sv
package tss_pkg;

   // session states
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_WAIT_DATA  = 3'd1;
   localparam logic [2:0] ST_WAIT_ACK   = 3'd2;
   localparam logic [2:0] ST_WAIT_LAST  = 3'd3;
   localparam logic [2:0] ST_AFTER_OACK = 3'd4;
   localparam logic [2:0] ST_READ_DONE  = 3'd5;
   localparam logic [2:0] ST_WRITE_DONE = 3'd6;
   localparam logic [2:0] ST_ERROR      = 3'd7;

   // packet to send
   localparam logic [1:0] SEND_NONE  = 2'd0;
   localparam logic [1:0] SEND_ACK   = 2'd1;
   localparam logic [1:0] SEND_DATA  = 2'd2;
   localparam logic [1:0] SEND_ERROR = 2'd3;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_ILLEGAL = 2'd1;
   localparam logic [1:0] ERR_FULL    = 2'd2;

   // item action
   localparam logic ACT_BEGIN  = 1'b0;
   localparam logic ACT_PACKET = 1'b1;

   // start state codes on begin
   localparam logic [1:0] START_WAIT_DATA  = 2'd0;
   localparam logic [1:0] START_WAIT_ACK   = 2'd1;
   localparam logic [1:0] START_AFTER_OACK = 2'd2;

   // tftp opcodes
   localparam logic [2:0] OP_RRQ   = 3'd1;
   localparam logic [2:0] OP_WRQ   = 3'd2;
   localparam logic [2:0] OP_DATA  = 3'd3;
   localparam logic [2:0] OP_ACK   = 3'd4;
   localparam logic [2:0] OP_ERROR = 3'd5;
   localparam logic [2:0] OP_OACK  = 3'd6;

   localparam logic [15:0] BLOCK_SIZE_RESET = 16'd512;

   typedef struct packed {
      logic        action;
      logic [1:0]  start_state;
      logic [15:0] start_block;
      logic [2:0]  packet_kind;
      logic [15:0] block_number;
      logic [15:0] data_length;
      logic        write_failed;
      logic [15:0] next_read_length;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  send_kind;
      logic [15:0] send_block;
      logic [1:0]  error_kind;
      logic [2:0]  session_state;
      logic        commit_write;
      logic        fetch_next;
      logic        close_stream;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  transfer_state;
      logic [15:0] current_block;
   } session_type;

endpackage

// File: hdl/tss_decide.sv
module tss_decide (
   input  tss_pkg::req_item_type item,
   input  tss_pkg::session_type  cur,
   input  logic [15:0]           block_size,
   output tss_pkg::session_type  nxt,
   output tss_pkg::rsp_item_type rsp
);
   import tss_pkg::*;

   logic [15:0] block_inc;
   logic        block_match;

   assign block_inc   = cur.current_block + 16'd1;
   assign block_match = (item.block_number == cur.current_block);

   always_comb begin
      nxt = cur;
      rsp = '0;
      if (item.action == ACT_BEGIN) begin
         nxt.current_block = item.start_block;
         case (item.start_state)
            START_WAIT_DATA:  nxt.transfer_state = ST_WAIT_DATA;
            START_WAIT_ACK:   nxt.transfer_state = ST_WAIT_ACK;
            START_AFTER_OACK: nxt.transfer_state = ST_AFTER_OACK;
            default:          nxt.transfer_state = ST_IDLE;
         endcase
      end else begin
         case (item.packet_kind)
            OP_DATA: begin
               if (!(cur.transfer_state == ST_WAIT_DATA ||
                     cur.transfer_state == ST_AFTER_OACK) ||
                   item.data_length > block_size || !block_match) begin
                  rsp.send_kind      = SEND_ERROR;
                  rsp.error_kind     = ERR_ILLEGAL;
                  nxt.transfer_state = ST_ERROR;
               end else if (item.write_failed) begin
                  rsp.send_kind      = SEND_ERROR;
                  rsp.error_kind     = ERR_FULL;
                  nxt.transfer_state = ST_ERROR;
               end else begin
                  rsp.commit_write = 1'b1;
                  if (item.data_length < block_size) begin
                     rsp.close_stream   = 1'b1;
                     nxt.transfer_state = ST_WRITE_DONE;
                  end else begin
                     nxt.transfer_state = ST_WAIT_DATA;
                  end
                  rsp.send_kind     = SEND_ACK;
                  rsp.send_block    = cur.current_block;
                  nxt.current_block = block_inc;
               end
            end
            OP_ACK: begin
               if ((cur.transfer_state == ST_WAIT_ACK ||
                    cur.transfer_state == ST_AFTER_OACK) && block_match) begin
                  nxt.current_block  = block_inc;
                  rsp.send_kind      = SEND_DATA;
                  rsp.send_block     = block_inc;
                  rsp.fetch_next     = 1'b1;
                  nxt.transfer_state = (item.next_read_length < block_size) ?
                                       ST_WAIT_LAST : ST_WAIT_ACK;
               end else if (cur.transfer_state == ST_WAIT_LAST && block_match) begin
                  rsp.close_stream   = 1'b1;
                  nxt.transfer_state = ST_READ_DONE;
               end else begin
                  rsp.send_kind      = SEND_ERROR;
                  rsp.error_kind     = ERR_ILLEGAL;
                  nxt.transfer_state = ST_ERROR;
               end
            end
            OP_ERROR: nxt.transfer_state = ST_ERROR;
            OP_RRQ, OP_WRQ, OP_OACK: begin
               rsp.send_kind      = SEND_ERROR;
               rsp.error_kind     = ERR_ILLEGAL;
               nxt.transfer_state = ST_ERROR;
            end
            default: ;
         endcase
      end
      rsp.session_state = nxt.transfer_state;
   end

endmodule

// File: hdl/tftp_server_transfer_sequencer.sv
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+----------------------------------------
// request   | req_valid   | req_stall   | req_action .. req_next_read_length
// response  | rsp_valid   | rsp_stall   | rsp_send_kind .. rsp_close_stream
// register  | csr_wr_en   | (none)      | csr_wr_data (block size)
//
// one item per cycle sustained while the response side does not stall; a request
// passes through the input register, decision logic and response register
// the session state and block counter update at the edge the response register
// loads, so the next item in the input register sees them the cycle after
// synchronous active-high reset clears both valid flags, the session to idle,
// the block counter to zero and the block size to 512
// a stalled response holds the input register; req_stall rises only while both
// registers are full and the response side stalls
module tftp_server_transfer_sequencer (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [1:0]  req_start_state,
   input  logic [15:0] req_start_block,
   input  logic [2:0]  req_packet_kind,
   input  logic [15:0] req_block_number,
   input  logic [15:0] req_data_length,
   input  logic        req_write_failed,
   input  logic [15:0] req_next_read_length,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_send_kind,
   output logic [15:0] rsp_send_block,
   output logic [1:0]  rsp_error_kind,
   output logic [2:0]  rsp_session_state,
   output logic        rsp_commit_write,
   output logic        rsp_fetch_next,
   output logic        rsp_close_stream,
   // block size register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import tss_pkg::*;

   // input register
   logic         in_valid_ff;
   req_item_type in_item_ff;
   req_item_type in_item_in;

   // response register
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type rsp_item_in;

   // session state and block size
   session_type  sess_ff;
   session_type  sess_in;
   logic [15:0]  block_size_ff;

   logic         out_free;   // response register can take a new item
   logic         process;    // item in input register decided this cycle

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_item_in = '{
      action:           req_action,
      start_state:      req_start_state,
      start_block:      req_start_block,
      packet_kind:      req_packet_kind,
      block_number:     req_block_number,
      data_length:      req_data_length,
      write_failed:     req_write_failed,
      next_read_length: req_next_read_length
   };

   tss_decide u_decide (
      .item       (in_item_ff),
      .cur        (sess_ff),
      .block_size (block_size_ff),
      .nxt        (sess_in),
      .rsp        (rsp_item_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_item_ff <= in_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   // session advances only with a decided item
   always_ff @(posedge clock) begin
      if (reset) begin
         sess_ff.transfer_state <= ST_IDLE;
         sess_ff.current_block  <= '0;
      end else if (process) begin
         sess_ff <= sess_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff <= BLOCK_SIZE_RESET;
      end else if (csr_wr_en) begin
         block_size_ff <= csr_wr_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_send_kind     = rsp_item_ff.send_kind;
   assign rsp_send_block    = rsp_item_ff.send_block;
   assign rsp_error_kind    = rsp_item_ff.error_kind;
   assign rsp_session_state = rsp_item_ff.session_state;
   assign rsp_commit_write  = rsp_item_ff.commit_write;
   assign rsp_fetch_next    = rsp_item_ff.fetch_next;
   assign rsp_close_stream  = rsp_item_ff.close_stream;

`ifndef SYNTHESIS
   // an error reply always leaves the session in the error state with a cause
   a_error_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.send_kind == SEND_ERROR |->
         rsp_item_ff.session_state == ST_ERROR && rsp_item_ff.error_kind != ERR_NONE)
      else $error("error reply without error state or cause");

   // a committed data block is always acknowledged
   a_commit_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.commit_write |-> rsp_item_ff.send_kind == SEND_ACK)
      else $error("commit without ack");

   // fetching a block means a data packet goes out and an ack is awaited
   a_fetch_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.fetch_next |->
         rsp_item_ff.send_kind == SEND_DATA &&
         (rsp_item_ff.session_state == ST_WAIT_ACK ||
          rsp_item_ff.session_state == ST_WAIT_LAST))
      else $error("fetch without data send");

   // the session only moves when an item is decided
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !process |=> $stable(sess_ff))
      else $error("session changed without an item");
`endif

endmodule
